// ===== rtl/rcsp_pkg.sv =====
package rcsp_pkg;

  localparam int SLOTS      = 64;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // fixed field widths of the request and result words
  localparam int REQ_W    = 2;
  localparam int SID_W    = 6;
  localparam int STATUS_W = 3;
  localparam int CNT_OUT_W = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_ACQUIRE = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_CREATE_FAIL = 3'd2,
    ST_BAD_HANDLE  = 3'd3,
    ST_NOT_IN_USE  = 3'd4
  } status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // latch request word, read slot entry
    logic exec;  // update slot, drive result
  } dp_cmd_t;

  // one slot entry in the table memory
  typedef struct packed {
    logic                  af;
    logic [COUNT_BITS-1:0] cnt;
  } slot_ent_t;

endpackage

// ===== rtl/rcsp_ctrl.sv =====
module rcsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output rcsp_pkg::dp_cmd_t cmd
);
  import rcsp_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy     = busy_r;
  assign cmd.load = (state_r == S_IDLE) && start;
  assign cmd.exec = (state_r == S_EXEC);

endmodule

// ===== rtl/rcsp_dp.sv =====
module rcsp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rcsp_pkg::dp_cmd_t              cmd,
  input  logic [rcsp_pkg::REQ_W-1:0]     req_type,
  input  logic [rcsp_pkg::SID_W-1:0]     slot_id,
  input  logic                           handle_valid,
  input  logic                           auto_free,
  input  logic                           create_ok,
  output logic                           res_valid,
  output logic [rcsp_pkg::STATUS_W-1:0]  res_status,
  output logic [rcsp_pkg::SID_W-1:0]     res_slot,
  output logic [rcsp_pkg::CNT_OUT_W-1:0] res_count,
  output logic                           res_freed
);
  import rcsp_pkg::*;

  // slot table
  logic [SLOTS-1:0] in_use_r;
  slot_ent_t        mem [SLOTS];
  slot_ent_t        rd_r;

  // latched request word
  logic [REQ_W-1:0] req_r;
  logic [SID_W-1:0] sid_r;
  logic             hvalid_r;
  logic             afree_r;
  logic             cok_r;

  // lowest free slot, refreshed every cycle
  logic [SLOT_W-1:0] ff_idx_nxt, ff_idx_r;
  logic              any_free_nxt, any_free_r;

  // update / result logic
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_ent_t         wr_data;
  logic              set_use, clr_use;
  logic [SLOT_W-1:0] use_idx;
  status_t           st_nxt;
  logic [SID_W-1:0]  slot_nxt;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic              freed_nxt;
  logic [SLOT_W-1:0] sid_idx;
  logic              sid_ok;
  logic [COUNT_BITS-1:0] cnt_upd;

  logic              valid_r;
  status_t           status_r;
  logic [SID_W-1:0]  slot_r;
  logic [COUNT_BITS-1:0] count_r;
  logic              freed_r;

  always_comb begin
    ff_idx_nxt   = '0;
    any_free_nxt = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        ff_idx_nxt   = SLOT_W'(i);
        any_free_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ff_idx_r   <= ff_idx_nxt;
    any_free_r <= any_free_nxt;
  end

  // request latch and table read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_type;
      sid_r    <= slot_id;
      hvalid_r <= handle_valid;
      afree_r  <= auto_free;
      cok_r    <= create_ok;
      rd_r     <= mem[slot_id[SLOT_W-1:0]];
    end
  end

  assign sid_idx = sid_r[SLOT_W-1:0];
  assign sid_ok  = hvalid_r && (32'(sid_r) < SLOTS);

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = sid_idx;
    wr_data   = rd_r;
    set_use   = 1'b0;
    clr_use   = 1'b0;
    use_idx   = sid_idx;
    st_nxt    = ST_OK;
    slot_nxt  = sid_r;
    cnt_nxt   = '0;
    freed_nxt = 1'b0;
    cnt_upd   = rd_r.cnt;

    unique case (req_r)
      REQ_ALLOC: begin
        if (!any_free_r) begin
          st_nxt   = ST_NO_FREE;
          slot_nxt = '0;
        end else if (!cok_r) begin
          st_nxt   = ST_CREATE_FAIL;
          slot_nxt = SID_W'(ff_idx_r);
        end else begin
          slot_nxt    = SID_W'(ff_idx_r);
          cnt_nxt     = COUNT_BITS'(1);
          wr_en       = 1'b1;
          wr_addr     = ff_idx_r;
          wr_data.cnt = COUNT_BITS'(1);
          wr_data.af  = afree_r;
          set_use     = 1'b1;
          use_idx     = ff_idx_r;
        end
      end
      REQ_ACQUIRE, REQ_RELEASE: begin
        if (!sid_ok) begin
          st_nxt = ST_BAD_HANDLE;
        end else if (!in_use_r[sid_idx]) begin
          st_nxt = ST_NOT_IN_USE;
        end else if (req_r == REQ_ACQUIRE) begin
          if (rd_r.cnt != CNT_MAX) cnt_upd = rd_r.cnt + COUNT_BITS'(1);
          cnt_nxt     = cnt_upd;
          wr_en       = 1'b1;
          wr_data.cnt = cnt_upd;
        end else begin
          if (rd_r.cnt != '0) cnt_upd = rd_r.cnt - COUNT_BITS'(1);
          if (cnt_upd == '0 && rd_r.af) begin
            clr_use   = 1'b1;
            freed_nxt = 1'b1;
          end else begin
            cnt_nxt     = cnt_upd;
            wr_en       = 1'b1;
            wr_data.cnt = cnt_upd;
          end
        end
      end
      default: begin
        st_nxt   = ST_BAD_HANDLE;
        slot_nxt = '0;
      end
    endcase
  end

  // table write (entries of free slots are dead, so no clear is needed)
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
      if (cmd.exec && set_use) in_use_r[use_idx] <= 1'b1;
      if (cmd.exec && clr_use) in_use_r[use_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= st_nxt;
      slot_r   <= slot_nxt;
      count_r  <= cnt_nxt;
      freed_r  <= freed_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_slot   = slot_r;
  assign res_count  = CNT_OUT_W'(count_r);
  assign res_freed  = freed_r;

endmodule

// ===== rtl/refcounted_slot_pool.sv =====
// Channel   Handshake             Fields
// -------   -------------------   ---------------------------------------------
// request   start && !busy        in_req_type, in_slot_id, in_handle_valid,
//                                 in_auto_free, in_create_ok
// result    out_valid (1 cycle)   out_status, out_granted_slot, out_count_after,
//                                 out_slot_freed
//
// On acceptance the slot entry is read from the table memory into a register;
// the execute state then does the read-modify-write and registers the result.
// out_valid pulses in the cycle after that; a new word is taken the same cycle.
// Synchronous active-low reset clears all in-use marks; counts need no clear
// since an entry is only used while its slot is in use.
// The receiver cannot stall: each result shows for exactly one cycle.
module refcounted_slot_pool (
  input  logic                           clk,
  input  logic                           rst_n,
  // request word
  input  logic                           start,
  output logic                           busy,
  input  logic [rcsp_pkg::REQ_W-1:0]     in_req_type,
  input  logic [rcsp_pkg::SID_W-1:0]     in_slot_id,
  input  logic                           in_handle_valid,
  input  logic                           in_auto_free,
  input  logic                           in_create_ok,
  // result word
  output logic                           out_valid,
  output logic [rcsp_pkg::STATUS_W-1:0]  out_status,
  output logic [rcsp_pkg::SID_W-1:0]     out_granted_slot,
  output logic [rcsp_pkg::CNT_OUT_W-1:0] out_count_after,
  output logic                           out_slot_freed
);
  import rcsp_pkg::*;

  dp_cmd_t cmd;

  // two-state sequencer: idle, then execute, then back to idle
  rcsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // slot table, free-slot search and result registers
  rcsp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_type     (in_req_type),
    .slot_id      (in_slot_id),
    .handle_valid (in_handle_valid),
    .auto_free    (in_auto_free),
    .create_ok    (in_create_ok),
    .res_valid    (out_valid),
    .res_status   (out_status),
    .res_slot     (out_granted_slot),
    .res_count    (out_count_after),
    .res_freed    (out_slot_freed)
  );

endmodule

// ===== verif/refcounted_slot_pool_test.sv =====
`timescale 1ns / 1ps

module refcounted_slot_pool_test;
  import rcsp_pkg::*;

  // req_type 3 has no package name; the pool answers it with a bad-handle status
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

  localparam int RESET_CYCLES = 7;
  localparam int HOT_SLOT     = 1;       // slot given a run of back-to-back acquires
  localparam int RUN_WORDS    = 8;
  localparam int RANDOM_WORDS = 1000;
  localparam int CHUNK_WORDS  = 100;     // idle mix and alloc bias change per chunk
  localparam int MAX_CYCLES   = 1_000_000;
  localparam int DRAIN_CYCLES = 4;       // read + RMW + strobe, plus margin
  localparam int MAX_REPORTS  = 10;

  // one request word as presented on the in_ ports
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [SID_W-1:0] sid;
    logic             hv;
    logic             af;
    logic             cok;
  } pool_req_t;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SID_W-1:0]     slot;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 freed;
  } pool_result_t;

  // directed row: typed = 1 means "want" is the expected word, else predict it
  typedef struct packed {
    pool_req_t    word;
    logic         typed;
    pool_result_t want;
  } dir_row_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 start           = 1'b0;
  logic [REQ_W-1:0]     in_req_type     = '0;
  logic [SID_W-1:0]     in_slot_id      = '0;
  logic                 in_handle_valid = 1'b0;
  logic                 in_auto_free    = 1'b0;
  logic                 in_create_ok    = 1'b0;
  logic                 busy;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [SID_W-1:0]     out_granted_slot;
  logic [CNT_OUT_W-1:0] out_count_after;
  logic                 out_slot_freed;

  // shadow copy of the slot table, updated at each accepted word
  logic [SLOTS-1:0]      slot_used     = '0;
  logic [SLOTS-1:0]      slot_autofree = '0;
  logic [COUNT_BITS-1:0] slot_refs [SLOTS];

  pool_result_t pending_results [$];   // oldest expected result word first
  dir_row_t     directed_rows [$];
  int           errors      = 0;
  int           cycle_count = 0;

  refcounted_slot_pool dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_slot_id      (in_slot_id),
    .in_handle_valid (in_handle_valid),
    .in_auto_free    (in_auto_free),
    .in_create_ok    (in_create_ok),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_granted_slot(out_granted_slot),
    .out_count_after (out_count_after),
    .out_slot_freed  (out_slot_freed)
  );

  always #1 clk = ~clk;

  // Applies one request to the shadow table and returns the result word the
  // pool must produce for it.
  function automatic pool_result_t apply_request(input pool_req_t w);
    pool_result_t res;
    int           lowest_free;
    int           idx;
    res         = '0;
    lowest_free = -1;
    for (idx = SLOTS - 1; idx >= 0; idx--)
      if (!slot_used[idx]) lowest_free = idx;
    idx = int'(w.sid);
    case (w.req)
      REQ_ALLOC: begin
        if (lowest_free < 0) begin
          res.status = ST_NO_FREE;            // slot and count stay zero
        end else if (!w.cok) begin
          // creation failed: report the candidate slot but leave it free
          res.status = ST_CREATE_FAIL;
          res.slot   = SID_W'(lowest_free);
        end else begin
          slot_used[lowest_free]     = 1'b1;
          slot_refs[lowest_free]     = COUNT_BITS'(1);
          slot_autofree[lowest_free] = w.af;
          res.status = ST_OK;
          res.slot   = SID_W'(lowest_free);
          res.cnt    = CNT_OUT_W'(slot_refs[lowest_free]);
        end
      end
      REQ_ACQUIRE, REQ_RELEASE: begin
        res.slot = w.sid;                     // error cases echo the handle
        if (!w.hv || idx >= SLOTS) begin
          res.status = ST_BAD_HANDLE;
        end else if (!slot_used[idx]) begin
          res.status = ST_NOT_IN_USE;
        end else if (w.req == REQ_ACQUIRE) begin
          // saturate at the ceiling rather than wrap
          if (slot_refs[idx] != CNT_MAX) slot_refs[idx] = slot_refs[idx] + 1'b1;
          res.status = ST_OK;
          res.cnt    = CNT_OUT_W'(slot_refs[idx]);
        end else begin
          // floor at zero; a zero count frees only auto-free slots
          if (slot_refs[idx] != '0) slot_refs[idx] = slot_refs[idx] - 1'b1;
          if (slot_refs[idx] == '0 && slot_autofree[idx]) begin
            slot_used[idx]     = 1'b0;
            slot_autofree[idx] = 1'b0;
            res.freed          = 1'b1;
          end
          res.status = ST_OK;
          res.cnt    = CNT_OUT_W'(slot_refs[idx]);
        end
      end
      default: begin
        res.status = ST_BAD_HANDLE;           // undefined request: all else zero
      end
    endcase
    return res;
  endfunction

  // Presents one word and holds it until the pool takes it (start && !busy at
  // an edge), then queues the expected result word. start is left high so a
  // back-to-back word never sees it drop.
  task automatic issue_word(input pool_req_t w, input logic typed,
                            input pool_result_t want);
    pool_result_t predicted;
    start           <= 1'b1;
    in_req_type     <= w.req;
    in_slot_id      <= w.sid;
    in_handle_valid <= w.hv;
    in_auto_free    <= w.af;
    in_create_ok    <= w.cok;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_request(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Random sender gap: with probability pct/100 per cycle, drop start and idle.
  task automatic sender_gap(input int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Result checker: every strobed word must match the oldest expectation.
  // The receiver cannot stall, so each out_valid cycle is one accepted word.
  always @(posedge clk) begin
    pool_result_t seen;
    pool_result_t want;
    if (rst_n && out_valid) begin
      seen = '{out_status, out_granted_slot, out_count_after, out_slot_freed};
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result word: status %0d slot %0d count %0d freed %0d",
                   seen.status, seen.slot, seen.cnt, seen.freed);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.slot !== want.slot ||
            seen.cnt !== want.cnt || seen.freed !== want.freed) begin
          // fields as status/slot/count/freed
          if (errors < MAX_REPORTS)
            $display("result mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.slot, want.cnt, want.freed,
                     seen.status, seen.slot, seen.cnt, seen.freed);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    pool_req_t w;
    int        n;
    int        idx;
    int        chunk;
    int        pct;
    int        pick;
    int        alloc_w;
    int        rel_w;

    for (idx = 0; idx < SLOTS; idx++) slot_refs[idx] = '0;

    // Directed table. Typed rows are the ones readable straight off an empty
    // pool or an error rule; the rest go through the predictor.
    //                    req          sid    hv    af    cok   typed  want
    directed_rows.push_back('{'{REQ_ALLOC,   6'd0,  1'b1, 1'b1, 1'b1}, 1'b1,
                              '{ST_OK, 6'd0, 16'd1, 1'b0}});
    // creation failure reports slot 1 but leaves it free
    directed_rows.push_back('{'{REQ_ALLOC,   6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
                              '{ST_CREATE_FAIL, 6'd1, 16'd0, 1'b0}});
    // handle fields are don't-care on allocate; slot 1 gets no auto-free
    directed_rows.push_back('{'{REQ_ALLOC,   6'd63, 1'b0, 1'b0, 1'b1}, 1'b1,
                              '{ST_OK, 6'd1, 16'd1, 1'b0}});
    directed_rows.push_back('{'{REQ_ACQUIRE, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{REQ_ACQUIRE, 6'd63, 1'b1, 1'b1, 1'b1}, 1'b1,
                              '{ST_NOT_IN_USE, 6'd63, 16'd0, 1'b0}});
    directed_rows.push_back('{'{REQ_RELEASE, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
                              '{ST_BAD_HANDLE, 6'd0, 16'd0, 1'b0}});
    directed_rows.push_back('{'{REQ_ACQUIRE, 6'd63, 1'b0, 1'b1, 1'b1}, 1'b1,
                              '{ST_BAD_HANDLE, 6'd63, 16'd0, 1'b0}});
    // undefined request type zeroes the slot field too
    directed_rows.push_back('{'{REQ_UNDEF,   6'd63, 1'b1, 1'b1, 1'b1}, 1'b1,
                              '{ST_BAD_HANDLE, 6'd0, 16'd0, 1'b0}});
    // slot 0 (auto-free): 2 -> 1 -> freed, then not in use
    directed_rows.push_back('{'{REQ_RELEASE, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{REQ_RELEASE, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{REQ_RELEASE, 6'd0,  1'b1, 1'b1, 1'b1}, 1'b0, '0});
    // slot 1 (no auto-free): hits zero, stays in use, floors at zero
    directed_rows.push_back('{'{REQ_RELEASE, 6'd1,  1'b1, 1'b0, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{REQ_RELEASE, 6'd1,  1'b1, 1'b1, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{REQ_ACQUIRE, 6'd1,  1'b1, 1'b0, 1'b1}, 1'b0, '0});
    // freed slot 0 is the lowest free one again
    directed_rows.push_back('{'{REQ_ALLOC,   6'd42, 1'b0, 1'b1, 1'b1}, 1'b0, '0});
    directed_rows.push_back('{'{REQ_RELEASE, 6'd42, 1'b1, 1'b0, 1'b0}, 1'b0, '0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < directed_rows.size(); n++) begin
      issue_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].want);
      sender_gap(20);
    end

    // Back-to-back acquires on the no-auto-free slot, then step down and
    // back up.
    w = '{REQ_ACQUIRE, SID_W'(HOT_SLOT), 1'b1, 1'b0, 1'b0};
    repeat (RUN_WORDS) issue_word(w, 1'b0, '0);
    w.req = REQ_RELEASE;
    issue_word(w, 1'b0, '0);
    w.req = REQ_ACQUIRE;
    issue_word(w, 1'b0, '0);

    // Fill the pool, then hit it with allocates while full (with and
    // without a successful creation).
    w = '{REQ_ALLOC, '0, 1'b0, 1'b1, 1'b1};
    while (!(&slot_used)) begin
      w.sid = SID_W'($urandom_range(SLOTS - 1));
      issue_word(w, 1'b0, '0);
      sender_gap(20);
    end
    issue_word(w, 1'b0, '0);
    w.cok = 1'b0;
    issue_word(w, 1'b0, '0);

    // Random traffic. Most words are well-formed acquires and releases on live
    // handles or allocates, so counts climb and slots churn; a slice is noise
    // (any type, any handle, valid or not). Each chunk picks an idle mix and
    // leans toward growing or draining the pool.
    for (chunk = 0; chunk < RANDOM_WORDS / CHUNK_WORDS; chunk++) begin
      case (chunk % 3)
        0:       pct = 0;
        1:       pct = 82;
        default: pct = 20;
      endcase
      if ($urandom_range(1) != 0) begin
        alloc_w = 55;
        rel_w   = 40;
      end else begin
        alloc_w = 15;
        rel_w   = 75;
      end
      for (n = 0; n < CHUNK_WORDS; n++) begin
        w.req = REQ_W'($urandom_range(3));
        w.sid = SID_W'($urandom_range(SLOTS - 1));
        w.hv  = 1'($urandom_range(1));
        w.af  = 1'($urandom_range(1));
        w.cok = 1'($urandom_range(1));
        pick  = $urandom_range(99);
        if (pick < 12) begin
          // noise word, fields as drawn
        end else if (pick < 12 + alloc_w || slot_used == '0) begin
          // auto-free mostly set so the pool can drain again
          w.req = REQ_ALLOC;
          w.af  = ($urandom_range(19) != 0);
          w.cok = ($urandom_range(9) != 0);
        end else begin
          idx = $urandom_range(SLOTS - 1);
          while (!slot_used[idx]) idx = (idx + 1) % SLOTS;
          w.sid = SID_W'(idx);
          w.hv  = 1'b1;
          w.req = ($urandom_range(99) < rel_w) ? REQ_RELEASE : REQ_ACQUIRE;
        end
        issue_word(w, 1'b0, '0);
        sender_gap(pct);
      end
    end
    start <= 1'b0;

    // drain: all results in, then a few quiet cycles to catch strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
